// ----- design/assert_macros.svh -----
// Assertion helpers shared by the RTL. Bodies are empty for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: ante implies cons");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: ante implies cons next cycle");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- design/wdt_regs_pkg.sv -----
`timescale 1ns / 1ps

package wdt_regs_pkg;

  // Counter width; the byte registers only reach bits 23:0.
  localparam int COUNT_BITS = 24;
  localparam int VIEW_BITS  = 24;
  localparam int WIDE_BITS  = (COUNT_BITS > VIEW_BITS) ? COUNT_BITS : VIEW_BITS;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_TICK  = 2'd2
  } func_t;

  localparam logic [7:0] OFF_CAUSE    = 8'h07;
  localparam logic [7:0] OFF_RELOAD_H = 8'h81;
  localparam logic [7:0] OFF_RELOAD_M = 8'h82;
  localparam logic [7:0] OFF_RELOAD_L = 8'h83;
  localparam logic [7:0] OFF_COUNT_H  = 8'h84;
  localparam logic [7:0] OFF_COUNT_M  = 8'h85;
  localparam logic [7:0] OFF_COUNT_L  = 8'h86;
  localparam logic [7:0] OFF_ENABLE   = 8'h87;
  localparam logic [7:0] OFF_PUNCH    = 8'h89;

  localparam logic [7:0] EXPIRY_CAUSE = 8'h66;
  localparam int         ENABLE_BIT   = 0;

  // Counter value as seen through the 24-bit byte window.
  function automatic logic [VIEW_BITS-1:0] to_view(input logic [COUNT_BITS-1:0] x);
    logic [WIDE_BITS-1:0] w;
    w = WIDE_BITS'(x);
    return w[VIEW_BITS-1:0];
  endfunction

  // Byte window back to counter width: masked when narrower, zero-filled when wider.
  function automatic logic [COUNT_BITS-1:0] to_count(input logic [VIEW_BITS-1:0] v);
    logic [WIDE_BITS-1:0] w;
    w = WIDE_BITS'(v);
    return w[COUNT_BITS-1:0];
  endfunction

endpackage

// ----- design/watchdog_timer_registers_top.sv -----
`timescale 1ns / 1ps
// Millisecond watchdog behind byte-wide registers.
// Input channel (in_valid / in_stall): each transaction is a bus write, a bus
// read or a one-millisecond tick (func), with reg_offset and write_data.
// Output channel (out_valid / out_stall): exactly one result per input
// transaction, in order: read_data (register byte on reads, else 0) and
// reset_request (1 when that tick made the watchdog expire).
// State updates and the result is registered at the edge that accepts the
// input. Throughput is one transaction per cycle while the skid register is
// empty; the register state and one decrement/compare are the whole path.
// When the receiver stalls, a second result is held in a skid register, so
// one more input is still taken; in_stall rises only while that skid
// register is full.
// Reset clears reload value, remaining count, enable and reboot cause, and
// empties both output registers.
`include "assert_macros.svh"

module watchdog_timer_registers_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  input  logic [7:0] reg_offset,
  input  logic [7:0] write_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       reset_request
);
  import wdt_regs_pkg::*;

  logic [COUNT_BITS-1:0] reload_value, reload_value_next;
  logic [COUNT_BITS-1:0] remaining_count, remaining_count_next;
  logic                  enabled, enabled_next;
  logic [7:0]            reboot_cause, reboot_cause_next;

  logic                  skid_valid;
  logic [7:0]            skid_read_data;
  logic                  skid_reset_request;

  logic                  accept;
  logic                  out_take;
  logic [7:0]            rd;
  logic                  req;
  logic [VIEW_BITS-1:0]  reload_view;
  logic [VIEW_BITS-1:0]  count_view;
  logic [COUNT_BITS-1:0] count_dec;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;

  assign reload_view = to_view(reload_value);
  assign count_view  = to_view(remaining_count);
  assign count_dec   = (remaining_count != '0) ? remaining_count - COUNT_BITS'(1)
                                               : remaining_count;

  always_comb begin
    reload_value_next    = reload_value;
    remaining_count_next = remaining_count;
    enabled_next         = enabled;
    reboot_cause_next    = reboot_cause;
    rd                   = '0;
    req                  = 1'b0;
    if (accept) begin
      case (func_t'(func))
        FUNC_WRITE: begin
          case (reg_offset)
            OFF_RELOAD_H: reload_value_next = to_count({write_data, reload_view[15:0]});
            OFF_RELOAD_M: reload_value_next =
                            to_count({reload_view[23:16], write_data, reload_view[7:0]});
            OFF_RELOAD_L: reload_value_next = to_count({reload_view[23:8], write_data});
            OFF_ENABLE:   enabled_next = write_data[ENABLE_BIT];
            OFF_PUNCH:    remaining_count_next = reload_value;
            default:      ;
          endcase
        end
        FUNC_READ: begin
          case (reg_offset)
            OFF_CAUSE:    rd = reboot_cause;
            OFF_RELOAD_H: rd = reload_view[23:16];
            OFF_RELOAD_M: rd = reload_view[15:8];
            OFF_RELOAD_L: rd = reload_view[7:0];
            OFF_COUNT_H:  rd = count_view[23:16];
            OFF_COUNT_M:  rd = count_view[15:8];
            OFF_COUNT_L:  rd = count_view[7:0];
            OFF_ENABLE:   rd = {7'd0, enabled};
            default:      rd = '0;
          endcase
        end
        FUNC_TICK: begin
          if (enabled) begin
            remaining_count_next = count_dec;
            // already at zero or just reached it: expire
            if (count_dec == '0) begin
              req               = 1'b1;
              reboot_cause_next = EXPIRY_CAUSE;
              enabled_next      = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reload_value    <= '0;
      remaining_count <= '0;
      enabled         <= 1'b0;
      reboot_cause    <= '0;
    end else begin
      reload_value    <= reload_value_next;
      remaining_count <= remaining_count_next;
      enabled         <= enabled_next;
      reboot_cause    <= reboot_cause_next;
    end
  end

  // Output register plus one skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (accept) begin
        if (!out_valid || out_take) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        read_data     <= skid_read_data;
        reset_request <= skid_reset_request;
      end
    end else if (accept) begin
      if (!out_valid || out_take) begin
        read_data     <= rd;
        reset_request <= req;
      end else begin
        skid_read_data     <= rd;
        skid_reset_request <= req;
      end
    end
  end

  `ASSERT_IMPLIES(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `ASSERT_IMPLIES(a_req_no_data, clk, rst, out_valid && reset_request, read_data == 8'd0)
  `ASSERT_NEXT(a_expiry_disables, clk, rst, accept && req, !enabled && reboot_cause == EXPIRY_CAUSE)
  `ASSERT_NEXT(a_stall_full_skid, clk, rst, out_valid && out_stall && accept, in_stall)

endmodule
